FILE: src/mcar_pkg.sv
// mcar_pkg: shared types and constants for the multi-channel angle ramp.
// Used by mcar_lane, mcar_merge and multi_channel_angle_ramp; no dependencies.
package mcar_pkg;

    // Channel count
    localparam int unsigned MAX_CHANNELS = 4;
    localparam int unsigned CHANNELS_DEF = 4;

    // Field widths
    localparam int unsigned CMD_W   = 2;
    localparam int unsigned CHAN_W  = 2;
    localparam int unsigned REQ_W   = 9;   // requested angle, signed
    localparam int unsigned ANGLE_W = 8;   // stored angle and limits, signed
    localparam int unsigned DRIVE_W = 8;   // drive value, unsigned
    localparam int unsigned DIFF_W  = 10;  // headroom for 90 - angle

    // Command codes
    localparam logic [CMD_W-1:0] CMD_TICK    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SET_ONE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SET_ALL = 2'd2;

    // Drive mapping
    localparam logic signed [DIFF_W-1:0] DRIVE_CENTER = 10'sd90;
    localparam logic signed [DIFF_W-1:0] DRIVE_MAX    = 10'sd180;

    // Limit registers: min/max pair per channel
    localparam int unsigned NUM_REGS  = 2 * MAX_CHANNELS;
    localparam int unsigned REG_IDX_W = $clog2(NUM_REGS);
    localparam int unsigned ADDR_W    = REG_IDX_W + 2;
    localparam int unsigned DATA_W    = 32;

    localparam logic [ANGLE_W-1:0] REG_RESET [NUM_REGS] = '{
        8'hA6,  // min_base     -90
        8'h5A,  // max_base      90
        8'hA6,  // min_shoulder -90
        8'h00,  // max_shoulder   0
        8'h00,  // min_elbow      0
        8'h5A,  // max_elbow     90
        8'hEC,  // min_gripper  -20
        8'h28   // max_gripper   40
    };

    // Per-lane result toward the merge stage
    typedef struct packed {
        logic [DRIVE_W-1:0] drive;
        logic               moving;
    } lane_status_t;

endpackage

FILE: src/mcar_lane.sv
// mcar_lane: one channel of the ramp - target clamp, one-degree step, drive map.
// Depends on mcar_pkg.
module mcar_lane
(
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       accept,
    input  logic                                       tick,
    input  logic                                       set_en,
    input  logic signed [mcar_pkg::REQ_W-1:0]          req_angle,
    input  logic signed [mcar_pkg::ANGLE_W-1:0]        lo,
    input  logic signed [mcar_pkg::ANGLE_W-1:0]        hi,
    output mcar_pkg::lane_status_t                     status
);

    logic signed [mcar_pkg::ANGLE_W-1:0] cur_reg;
    logic signed [mcar_pkg::ANGLE_W-1:0] cur_next;
    logic signed [mcar_pkg::ANGLE_W-1:0] tgt_reg;
    logic signed [mcar_pkg::ANGLE_W-1:0] tgt_next;
    logic signed [mcar_pkg::ANGLE_W-1:0] clamped;
    logic signed [mcar_pkg::REQ_W-1:0]   lo_x;
    logic signed [mcar_pkg::REQ_W-1:0]   hi_x;
    logic signed [mcar_pkg::DIFF_W-1:0]  diff;

    assign lo_x = mcar_pkg::REQ_W'(lo);
    assign hi_x = mcar_pkg::REQ_W'(hi);

    // Minimum test wins when the limits cross
    always_comb
    begin
        if (req_angle < lo_x)
        begin
            clamped = lo;
        end
        else if (req_angle > hi_x)
        begin
            clamped = hi;
        end
        else
        begin
            clamped = req_angle[mcar_pkg::ANGLE_W-1:0];
        end
    end

    assign tgt_next = set_en ? clamped : tgt_reg;

    always_comb
    begin
        cur_next = cur_reg;
        if (tick)
        begin
            if (cur_reg < tgt_reg)
            begin
                cur_next = cur_reg + 8'sd1;
            end
            else if (cur_reg > tgt_reg)
            begin
                cur_next = cur_reg - 8'sd1;
            end
        end
    end

    assign diff = mcar_pkg::DRIVE_CENTER - mcar_pkg::DIFF_W'(cur_next);

    always_comb
    begin
        status.moving = tick ? (cur_reg != tgt_reg) : (cur_reg != tgt_next);
        if (diff < 0)
        begin
            status.drive = '0;
        end
        else if (diff > mcar_pkg::DRIVE_MAX)
        begin
            status.drive = mcar_pkg::DRIVE_MAX[mcar_pkg::DRIVE_W-1:0];
        end
        else
        begin
            status.drive = diff[mcar_pkg::DRIVE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg <= '0;
            tgt_reg <= '0;
        end
        else if (accept)
        begin
            cur_reg <= cur_next;
            tgt_reg <= tgt_next;
        end
    end

endmodule

FILE: src/mcar_merge.sv
// mcar_merge: combines lane results into one response and holds it in the
// output register. Depends on mcar_pkg.
module mcar_merge
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  mcar_pkg::lane_status_t                lanes [mcar_pkg::MAX_CHANNELS],
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [mcar_pkg::DRIVE_W-1:0]          drive [mcar_pkg::MAX_CHANNELS],
    output logic                                  moving
);

    logic                         out_valid_reg;
    logic                         out_valid_next;
    logic [mcar_pkg::DRIVE_W-1:0] drive_reg [mcar_pkg::MAX_CHANNELS];
    logic                         moving_reg;
    logic                         moving_any;
    logic                         accept;

    // Output register frees up in the same cycle it is drained
    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        moving_any = 1'b0;
        for (int i = 0; i < mcar_pkg::MAX_CHANNELS; i++)
        begin
            moving_any = moving_any | lanes[i].moving;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int i = 0; i < mcar_pkg::MAX_CHANNELS; i++)
            begin
                drive_reg[i] <= lanes[i].drive;
            end
            moving_reg <= moving_any;
        end
    end

    assign out_valid = out_valid_reg;
    assign drive     = drive_reg;
    assign moving    = moving_reg;

endmodule

FILE: src/multi_channel_angle_ramp.sv
// multi_channel_angle_ramp: top level of the four-channel servo angle ramp.
// Depends on mcar_pkg, mcar_lane and mcar_merge.
//
// Each request is one of: tick (command 0) moves every channel's current angle
// one degree toward its target; set-one (command 1) clamps angle to the
// channel's min/max limits and stores it as that channel's target; set-all
// (command 2) does the same for all channels from target_ch0..target_ch3.
// Command 3 and a channel index at or above CHANNELS leave state alone.
// Every request gives exactly one response: drive_chN = 90 - current angle,
// saturated to 0..180 (0 for channels not built), and moving, which on a tick
// says some channel stepped and otherwise says some channel still differs
// from its target. Limits cross-checking: if min exceeds max, an angle below
// min gets min, anything else above max gets max. Throughput is one request
// per clock: each channel lane does its clamp, compare and +/-1 step
// combinationally and the merge stage registers the response, which appears
// in the cycle after the request is taken, and a new request is taken while
// a response waits, as long as out_ready drains it. Limit registers sit on
// an APB port at byte address 4*i (min/max per channel, pready always high);
// the user must change them only while the block is idle, and the block
// itself does not enforce this. No clearing pass is needed after reset.
module multi_channel_angle_ramp
#(
    parameter int unsigned CHANNELS = mcar_pkg::CHANNELS_DEF
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    // request channel
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [mcar_pkg::CMD_W-1:0]           command,
    input  logic [mcar_pkg::CHAN_W-1:0]          channel,
    input  logic signed [mcar_pkg::REQ_W-1:0]    angle,
    input  logic signed [mcar_pkg::REQ_W-1:0]    target_ch0,
    input  logic signed [mcar_pkg::REQ_W-1:0]    target_ch1,
    input  logic signed [mcar_pkg::REQ_W-1:0]    target_ch2,
    input  logic signed [mcar_pkg::REQ_W-1:0]    target_ch3,
    // response channel
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [mcar_pkg::DRIVE_W-1:0]         drive_ch0,
    output logic [mcar_pkg::DRIVE_W-1:0]         drive_ch1,
    output logic [mcar_pkg::DRIVE_W-1:0]         drive_ch2,
    output logic [mcar_pkg::DRIVE_W-1:0]         drive_ch3,
    output logic                                 moving,
    // APB limit registers
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [mcar_pkg::ADDR_W-1:0]          paddr,
    input  logic [mcar_pkg::DATA_W-1:0]          pwdata,
    output logic [mcar_pkg::DATA_W-1:0]          prdata,
    output logic                                 pready
);

    logic [mcar_pkg::ANGLE_W-1:0]        cfg_reg [mcar_pkg::NUM_REGS];
    logic [mcar_pkg::REG_IDX_W-1:0]      cfg_idx;
    logic                                cfg_we;

    logic signed [mcar_pkg::REQ_W-1:0]   set_all_req [mcar_pkg::MAX_CHANNELS];
    mcar_pkg::lane_status_t              lane_status [mcar_pkg::MAX_CHANNELS];
    logic [mcar_pkg::DRIVE_W-1:0]        drive_out   [mcar_pkg::MAX_CHANNELS];
    logic                                accept;
    logic                                tick;

    // ---------------- limit registers ----------------
    assign pready  = 1'b1;
    assign cfg_idx = paddr[mcar_pkg::ADDR_W-1:2];
    assign cfg_we  = psel && penable && pwrite;
    assign prdata  = {{(mcar_pkg::DATA_W - mcar_pkg::ANGLE_W){1'b0}}, cfg_reg[cfg_idx]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < mcar_pkg::NUM_REGS; i++)
            begin
                cfg_reg[i] <= mcar_pkg::REG_RESET[i];
            end
        end
        else if (cfg_we)
        begin
            cfg_reg[cfg_idx] <= pwdata[mcar_pkg::ANGLE_W-1:0];
        end
    end

    // ---------------- channel lanes ----------------
    assign accept = in_valid && in_ready;
    assign tick   = (command == mcar_pkg::CMD_TICK);

    assign set_all_req[0] = target_ch0;
    assign set_all_req[1] = target_ch1;
    assign set_all_req[2] = target_ch2;
    assign set_all_req[3] = target_ch3;

    for (genvar g = 0; g < mcar_pkg::MAX_CHANNELS; g++)
    begin : g_lane
        if (g < CHANNELS)
        begin : g_on
            logic                              set_en;
            logic signed [mcar_pkg::REQ_W-1:0] req;

            assign set_en = (command == mcar_pkg::CMD_SET_ALL)
                         || ((command == mcar_pkg::CMD_SET_ONE)
                             && (channel == mcar_pkg::CHAN_W'(g)));
            assign req    = (command == mcar_pkg::CMD_SET_ALL) ? set_all_req[g] : angle;

            mcar_lane u_lane
            (
                .clk       (clk),
                .rst_n     (rst_n),
                .accept    (accept),
                .tick      (tick),
                .set_en    (set_en),
                .req_angle (req),
                .lo        ($signed(cfg_reg[2*g])),
                .hi        ($signed(cfg_reg[2*g+1])),
                .status    (lane_status[g])
            );
        end
        else
        begin : g_off
            // channel not built: drive 0, never moving
            assign lane_status[g] = '0;
        end
    end

    // ---------------- merge and output register ----------------
    mcar_merge u_merge
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .lanes     (lane_status),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .drive     (drive_out),
        .moving    (moving)
    );

    assign drive_ch0 = drive_out[0];
    assign drive_ch1 = drive_out[1];
    assign drive_ch2 = drive_out[2];
    assign drive_ch3 = drive_out[3];

    // ---------------- assertions ----------------
    // Request side stalls only while a response is stuck
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (out_valid && !out_ready))
        else $error("in_ready low without a blocked response");

    // Every accepted request shows up as a response next cycle
    a_resp_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> out_valid)
        else $error("accepted request produced no response");

    // Drive values stay within the servo range
    a_drive_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (drive_ch0 <= 8'd180 && drive_ch1 <= 8'd180
                       && drive_ch2 <= 8'd180 && drive_ch3 <= 8'd180))
        else $error("drive value beyond 180");

endmodule

FILE: test/multi_channel_angle_ramp_tb.sv
// multi_channel_angle_ramp_tb: self-checking testbench for the four-channel angle ramp.
// Depends on mcar_pkg and the multi_channel_angle_ramp RTL; reads no files.
module multi_channel_angle_ramp_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // ------------------------------------------------------------------
    // Run constants
    // ------------------------------------------------------------------
    localparam int CLK_PERIOD     = 20;
    localparam int RESET_CYCLES   = 6;
    localparam int NUM_CH         = 4;
    localparam int IDLE_PCT       = 23;   // chance per cycle of a gap or a stall
    localparam int DRAIN_CYCLES   = 4;    // extra wait once every response is back
    localparam int WATCHDOG_LIMIT = 2000; // cycles with no handshake at all

    // The one command code the package leaves unnamed
    localparam logic [mcar_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

    // Limit register map, one min/max pair per channel
    typedef enum int unsigned {
        REG_MIN_BASE,
        REG_MAX_BASE,
        REG_MIN_SHOULDER,
        REG_MAX_SHOULDER,
        REG_MIN_ELBOW,
        REG_MAX_ELBOW,
        REG_MIN_GRIPPER,
        REG_MAX_GRIPPER
    } limit_reg_e;

    typedef logic [mcar_pkg::ANGLE_W-1:0] limit_set_t [mcar_pkg::NUM_REGS];

    // One request as driven onto the input ports
    typedef struct packed {
        logic [mcar_pkg::CMD_W-1:0]              cmd;
        logic [mcar_pkg::CHAN_W-1:0]             chan;
        logic [mcar_pkg::REQ_W-1:0]              ang;
        logic [NUM_CH-1:0][mcar_pkg::REQ_W-1:0]  tgt;
    } ramp_request_t;

    // One response as expected on the output ports
    typedef struct packed {
        logic [NUM_CH-1:0][mcar_pkg::DRIVE_W-1:0] drive;
        logic                                     moving;
    } ramp_status_t;

    // ------------------------------------------------------------------
    // DUT connections, all inputs known from time zero
    // ------------------------------------------------------------------
    logic                                 clk        = 1'b0;
    logic                                 rst_n      = 1'b0;
    logic                                 in_valid   = 1'b0;
    logic                                 in_ready;
    logic [mcar_pkg::CMD_W-1:0]           command    = mcar_pkg::CMD_TICK;
    logic [mcar_pkg::CHAN_W-1:0]          channel    = '0;
    logic signed [mcar_pkg::REQ_W-1:0]    angle      = '0;
    logic signed [mcar_pkg::REQ_W-1:0]    target_ch0 = '0;
    logic signed [mcar_pkg::REQ_W-1:0]    target_ch1 = '0;
    logic signed [mcar_pkg::REQ_W-1:0]    target_ch2 = '0;
    logic signed [mcar_pkg::REQ_W-1:0]    target_ch3 = '0;
    logic                                 out_valid;
    logic                                 out_ready  = 1'b0;
    logic [mcar_pkg::DRIVE_W-1:0]         drive_ch0;
    logic [mcar_pkg::DRIVE_W-1:0]         drive_ch1;
    logic [mcar_pkg::DRIVE_W-1:0]         drive_ch2;
    logic [mcar_pkg::DRIVE_W-1:0]         drive_ch3;
    logic                                 moving;
    logic                                 psel       = 1'b0;
    logic                                 penable    = 1'b0;
    logic                                 pwrite     = 1'b0;
    logic [mcar_pkg::ADDR_W-1:0]          paddr      = '0;
    logic [mcar_pkg::DATA_W-1:0]          pwdata     = '0;
    logic [mcar_pkg::DATA_W-1:0]          prdata;
    logic                                 pready;

    multi_channel_angle_ramp i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .command    (command),
        .channel    (channel),
        .angle      (angle),
        .target_ch0 (target_ch0),
        .target_ch1 (target_ch1),
        .target_ch2 (target_ch2),
        .target_ch3 (target_ch3),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .drive_ch0  (drive_ch0),
        .drive_ch1  (drive_ch1),
        .drive_ch2  (drive_ch2),
        .drive_ch3  (drive_ch3),
        .moving     (moving),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    // ------------------------------------------------------------------
    // Shadow state of the ramp: angles, targets and the limit registers
    // as the block should hold them after every accepted request.
    // ------------------------------------------------------------------
    logic signed [mcar_pkg::ANGLE_W-1:0] cur_angle [NUM_CH];
    logic signed [mcar_pkg::ANGLE_W-1:0] tgt_angle [NUM_CH];
    limit_set_t                          limit_reg;

    ramp_status_t status_q [$];   // responses still owed by the block

    ramp_status_t                 want_status;
    logic [mcar_pkg::DRIVE_W-1:0] seen_drive [NUM_CH];

    int  fail_count     = 0;
    int  requests_sent  = 0;
    int  responses_seen = 0;
    int  limit_settings = 1;      // the reset values count as the first
    int  quiet_cycles   = 0;
    bit  no_idle        = 1'b0;   // suppresses gaps and stalls on both sides

    // ------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------
    initial
    begin
        forever
        begin
            #(CLK_PERIOD / 2) clk = ~clk;
        end
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Clamp to the channel's limits. With min above max the min test wins,
    // so a crossed pair maps everything onto one of the two bounds.
    function automatic logic signed [mcar_pkg::ANGLE_W-1:0] clamp_angle(
        int ch, logic signed [mcar_pkg::REQ_W-1:0] a);
        int lo;
        int hi;
        int v;
        lo = $signed(limit_reg[2 * ch]);
        hi = $signed(limit_reg[2 * ch + 1]);
        v  = a;
        if (v < lo)
            v = lo;
        else if (v > hi)
            v = hi;
        return v[mcar_pkg::ANGLE_W-1:0];
    endfunction

    // Drive is 90 minus the logical angle, saturated into 0..180; limits
    // wider than +/-90 can push the angle past either end.
    function automatic logic [mcar_pkg::DRIVE_W-1:0] drive_value(
        logic signed [mcar_pkg::ANGLE_W-1:0] a);
        int d;
        d = 90 - int'(a);
        if (d < 0)
            d = 0;
        if (d > 180)
            d = 180;
        return d[mcar_pkg::DRIVE_W-1:0];
    endfunction

    // Apply one request to the shadow state and return the response it owes.
    function automatic ramp_status_t predict_status(ramp_request_t r);
        ramp_status_t s;
        logic         mv;
        mv = 1'b0;
        if (r.cmd == mcar_pkg::CMD_TICK)
        begin
            for (int i = 0; i < NUM_CH; i++)
            begin
                if (cur_angle[i] < tgt_angle[i])
                begin
                    cur_angle[i] = cur_angle[i] + 1;
                    mv = 1'b1;
                end
                else if (cur_angle[i] > tgt_angle[i])
                begin
                    cur_angle[i] = cur_angle[i] - 1;
                    mv = 1'b1;
                end
            end
        end
        else
        begin
            // The unused code leaves targets alone but still reports
            // whether anything is left to travel.
            if (r.cmd == mcar_pkg::CMD_SET_ONE)
            begin
                if (int'(r.chan) < NUM_CH)
                    tgt_angle[r.chan] = clamp_angle(int'(r.chan), r.ang);
            end
            else if (r.cmd == mcar_pkg::CMD_SET_ALL)
            begin
                for (int i = 0; i < NUM_CH; i++)
                    tgt_angle[i] = clamp_angle(i, r.tgt[i]);
            end
            for (int i = 0; i < NUM_CH; i++)
                if (cur_angle[i] != tgt_angle[i])
                    mv = 1'b1;
        end
        for (int i = 0; i < NUM_CH; i++)
            s.drive[i] = drive_value(cur_angle[i]);
        s.moving = mv;
        return s;
    endfunction

    // ------------------------------------------------------------------
    // Request builders
    // ------------------------------------------------------------------
    function automatic ramp_request_t make_request(logic [mcar_pkg::CMD_W-1:0] cmd,
                                                   int chan, int ang,
                                                   int t0, int t1, int t2, int t3);
        ramp_request_t r;
        r.cmd    = cmd;
        r.chan   = chan[mcar_pkg::CHAN_W-1:0];
        r.ang    = ang[mcar_pkg::REQ_W-1:0];
        r.tgt[0] = t0[mcar_pkg::REQ_W-1:0];
        r.tgt[1] = t1[mcar_pkg::REQ_W-1:0];
        r.tgt[2] = t2[mcar_pkg::REQ_W-1:0];
        r.tgt[3] = t3[mcar_pkg::REQ_W-1:0];
        return r;
    endfunction

    // Angle within -180..180, with the two ends picked more often.
    function automatic int random_angle();
        if ($urandom_range(9) == 0)
            return ($urandom_range(1) == 1) ? 180 : -180;
        return int'($urandom_range(360)) - 180;
    endfunction

    // Every field random; fields the command does not use are noise.
    function automatic ramp_request_t random_request(logic [mcar_pkg::CMD_W-1:0] cmd);
        return make_request(cmd, int'($urandom_range(NUM_CH - 1)), random_angle(),
                            random_angle(), random_angle(), random_angle(), random_angle());
    endfunction

    function automatic limit_set_t uniform_limits(int lo, int hi);
        limit_set_t s;
        for (int i = 0; i < NUM_CH; i++)
        begin
            s[2 * i]     = lo[mcar_pkg::ANGLE_W-1:0];
            s[2 * i + 1] = hi[mcar_pkg::ANGLE_W-1:0];
        end
        return s;
    endfunction

    // Random pair per channel over the full 8-bit range, ordered or crossed.
    function automatic limit_set_t random_limits(bit crossed);
        limit_set_t s;
        int a;
        int b;
        for (int i = 0; i < NUM_CH; i++)
        begin
            a = int'($urandom_range(255)) - 128;
            b = int'($urandom_range(255)) - 128;
            if ((a > b) != crossed)
            begin
                s[2 * i]     = b[mcar_pkg::ANGLE_W-1:0];
                s[2 * i + 1] = a[mcar_pkg::ANGLE_W-1:0];
            end
            else
            begin
                s[2 * i]     = a[mcar_pkg::ANGLE_W-1:0];
                s[2 * i + 1] = b[mcar_pkg::ANGLE_W-1:0];
            end
        end
        return s;
    endfunction

    // ------------------------------------------------------------------
    // Request driver: random gap, then hold valid and payload until the
    // block takes the request. Valid is left high on return so that a
    // back-to-back request never toggles it within one time step.
    // ------------------------------------------------------------------
    task automatic send_request(ramp_request_t r);
        while (!no_idle && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        command    <= r.cmd;
        channel    <= r.chan;
        angle      <= r.ang;
        target_ch0 <= r.tgt[0];
        target_ch1 <= r.tgt[1];
        target_ch2 <= r.tgt[2];
        target_ch3 <= r.tgt[3];
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        status_q.push_back(predict_status(r));
        requests_sent++;
    endtask

    // Drop valid and wait until every owed response is back, plus the
    // latency of the response register.
    task automatic drain_responses();
        in_valid <= 1'b0;
        while (status_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // APB: write one limit register, then read it back on the next
    // transfer. Only called with the request side idle; psel stays high
    // on return so back-to-back transfers chain, the caller releases it.
    // ------------------------------------------------------------------
    task automatic write_limit(limit_reg_e idx, logic [mcar_pkg::ANGLE_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= mcar_pkg::ADDR_W'(int'(idx) * 4);
        pwdata  <= {{(mcar_pkg::DATA_W - mcar_pkg::ANGLE_W){val[mcar_pkg::ANGLE_W-1]}}, val};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        limit_reg[idx] = val;
        // read-back setup follows the write access directly
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata[mcar_pkg::ANGLE_W-1:0] !== val)
        begin
            $error("prdata reg %0d: expected %0h, actual %0h", int'(idx), val,
                   prdata[mcar_pkg::ANGLE_W-1:0]);
            fail_count++;
        end
    endtask

    task automatic load_limits(limit_set_t lims);
        drain_responses();
        for (int i = 0; i < mcar_pkg::NUM_REGS; i++)
            write_limit(limit_reg_e'(i), lims[i]);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        limit_settings++;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset limits: clamping at both ends of every channel, set-one on each
    // channel, the unused command, ramping until the channels settle, and
    // a set that equals the current angle.
    task automatic test_default_limits();
        send_request(make_request(mcar_pkg::CMD_SET_ALL, 0, 0, -180, 180, -180, 180));
        repeat (3) send_request(make_request(mcar_pkg::CMD_TICK, 3, -1, -1, -1, -1, -1));
        send_request(make_request(mcar_pkg::CMD_SET_ALL, 3, 255, 180, -180, 180, -180));
        send_request(make_request(mcar_pkg::CMD_TICK, 0, 0, 0, 0, 0, 0));
        send_request(make_request(mcar_pkg::CMD_SET_ONE, 0, -180, 0, 0, 0, 0));
        send_request(make_request(mcar_pkg::CMD_SET_ONE, 1, 180, 0, 0, 0, 0));
        send_request(make_request(mcar_pkg::CMD_SET_ONE, 2, -180, 0, 0, 0, 0));
        send_request(make_request(mcar_pkg::CMD_SET_ONE, 3, 180, 0, 0, 0, 0));
        send_request(make_request(CMD_UNUSED, 2, 180, 180, 180, 180, 180));
        send_request(make_request(mcar_pkg::CMD_SET_ONE, 3, -5, 0, 0, 0, 0));
        send_request(make_request(mcar_pkg::CMD_SET_ALL, 1, 0, 0, 0, 0, 0));
        // channels sit at most a few degrees off; the last ticks see no motion
        repeat (6) send_request(make_request(mcar_pkg::CMD_TICK, 1, 0, 0, 0, 0, 0));
        send_request(make_request(mcar_pkg::CMD_SET_ONE, 2, 0, 0, 0, 0, 0));
    endtask

    // Crossed limits: anything below min gets min, everything else gets max.
    task automatic test_crossed_limits();
        load_limits(uniform_limits(30, -30));
        send_request(make_request(mcar_pkg::CMD_SET_ONE, 0, -100, 0, 0, 0, 0));
        send_request(make_request(mcar_pkg::CMD_SET_ONE, 1, 29, 0, 0, 0, 0));
        send_request(make_request(mcar_pkg::CMD_SET_ONE, 2, 30, 0, 0, 0, 0));
        send_request(make_request(mcar_pkg::CMD_SET_ONE, 3, 180, 0, 0, 0, 0));
        send_request(make_request(mcar_pkg::CMD_SET_ALL, 0, 0, -180, 29, 30, 180));
        repeat (2) send_request(make_request(mcar_pkg::CMD_TICK, 2, 0, 0, 0, 0, 0));
    endtask

    // Random phase: mostly a set followed by a run of ticks, either a short
    // run or a long one that lets channels reach their targets, and some
    // loose ticks and unused codes in between.
    task automatic test_random_phase(limit_set_t lims, int count);
        int sent;
        int run;
        int pick;
        ramp_request_t r;
        load_limits(lims);
        sent = 0;
        while (sent < count)
        begin
            pick = int'($urandom_range(99));
            if (pick < 40)
                r = random_request(mcar_pkg::CMD_SET_ALL);
            else if (pick < 80)
                r = random_request(mcar_pkg::CMD_SET_ONE);
            else if (pick < 88)
                r = random_request(CMD_UNUSED);
            else
                r = random_request(mcar_pkg::CMD_TICK);
            send_request(r);
            sent++;
            run = ($urandom_range(3) == 0) ? int'($urandom_range(260))
                                           : int'($urandom_range(8));
            while (run > 0 && sent < count)
            begin
                send_request(random_request(mcar_pkg::CMD_TICK));
                sent++;
                run--;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Response checker and receiver stall. Outputs are sampled at the edge
    // before any update of that edge lands; out_ready moves by NBA.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            responses_seen++;
            if (status_q.size() == 0)
            begin
                $error("response with no request outstanding");
                fail_count++;
            end
            else
            begin
                want_status   = status_q.pop_front();
                seen_drive[0] = drive_ch0;
                seen_drive[1] = drive_ch1;
                seen_drive[2] = drive_ch2;
                seen_drive[3] = drive_ch3;
                for (int i = 0; i < NUM_CH; i++)
                begin
                    if (seen_drive[i] !== want_status.drive[i])
                    begin
                        $error("drive_ch%0d: expected %0d, actual %0d", i,
                               want_status.drive[i], seen_drive[i]);
                        fail_count++;
                    end
                end
                if (moving !== want_status.moving)
                begin
                    $error("moving: expected %0d, actual %0d", want_status.moving, moving);
                    fail_count++;
                end
            end
        end
        out_ready <= rst_n && (no_idle || $urandom_range(99) >= IDLE_PCT);
    end

    // ------------------------------------------------------------------
    // Watchdog: any handshake on either channel restarts the count
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequence of tests
    // ------------------------------------------------------------------
    initial
    begin
        limit_reg = mcar_pkg::REG_RESET;
        for (int i = 0; i < NUM_CH; i++)
        begin
            cur_angle[i] = '0;
            tgt_angle[i] = '0;
        end

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_default_limits();
        test_crossed_limits();

        // reset values, full 8-bit span (drive saturates at both ends),
        // a gap-free stretch at +/-90, random ordered and crossed pairs,
        // and the most extreme crossed pair
        test_random_phase(mcar_pkg::REG_RESET, 200);
        test_random_phase(uniform_limits(-128, 127), 220);
        no_idle = 1'b1;
        test_random_phase(uniform_limits(-90, 90), 200);
        no_idle = 1'b0;
        test_random_phase(random_limits(1'b0), 200);
        test_random_phase(random_limits(1'b1), 180);
        test_random_phase(uniform_limits(127, -128), 200);

        drain_responses();

        $display("Ran %0d requests and checked %0d responses over %0d limit settings,",
                 requests_sent, responses_seen, limit_settings);
        $display("covering clamping, crossed limits, drive saturation and idle-free bursts.");
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

FILE: multi_channel_angle_ramp.f
src/mcar_pkg.sv
src/mcar_lane.sv
src/mcar_merge.sv
src/multi_channel_angle_ramp.sv
test/multi_channel_angle_ramp_tb.sv
